### src/fns_pkg.sv
// Shared constants, types and codes for the five-number summary block.
// Used by fns_ctrl, fns_dp and the top level five_number_summary.
package fns_pkg;

    localparam int MAX_DISTINCT = 256;
    localparam int MAX_SAMPLES  = 65535;

    localparam int ADDR_W  = $clog2(MAX_DISTINCT);
    localparam int USED_W  = ADDR_W + 1;
    localparam int DATA_W  = 32;
    localparam int CNT_W   = 16;
    localparam int RANK_W  = CNT_W + 1;
    localparam int SUM_W   = 48;
    localparam int DCNT_W  = $clog2(SUM_W);

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DISTINCT = 2'd1;
    localparam logic [1:0] ST_SAMPLES  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic drop_samples;
        logic drop_distinct;
        logic addr_clr;
        logic addr_inc;
        logic rd;
        logic wr_inc;
        logic wr_new;
        logic wr_held;
        logic bump_used;
        logic eval_step;
        logic div_start;
        logic div_step;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic at_end;
        logic eq;
        logic gt;
        logic dist_full;
        logic samp_full;
        logic last_entry;
        logic is_last;
        logic empty;
        logic div_last;
        logic out_free;
    } t_stat;

endpackage

### src/fns_ctrl.sv
// Controller state machine for the five-number summary block.
// Depends on fns_pkg for the command and status structs.
module fns_ctrl import fns_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_CHECK = 11'b000_0000_0010,
        S_RD    = 11'b000_0000_0100,
        S_EV    = 11'b000_0000_1000,
        S_SH_RD = 11'b000_0001_0000,
        S_SH_EV = 11'b000_0010_0000,
        S_AFTER = 11'b000_0100_0000,
        S_E_RD  = 11'b000_1000_0000,
        S_E_EV  = 11'b001_0000_0000,
        S_DIV   = 11'b010_0000_0000,
        S_OUT   = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.samp_full) begin
                    o_cmd.drop_samples = 1'b1;
                    n_state            = S_AFTER;
                end else begin
                    o_cmd.addr_clr = 1'b1;
                    n_state        = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EV;
            end
            S_EV: begin
                if (i_stat.at_end) begin
                    if (i_stat.dist_full) begin
                        o_cmd.drop_distinct = 1'b1;
                    end else begin
                        o_cmd.wr_new    = 1'b1;
                        o_cmd.bump_used = 1'b1;
                    end
                    n_state = S_AFTER;
                end else if (i_stat.eq) begin
                    o_cmd.wr_inc = 1'b1;
                    n_state      = S_AFTER;
                end else if (i_stat.gt) begin
                    if (i_stat.dist_full) begin
                        o_cmd.drop_distinct = 1'b1;
                        n_state             = S_AFTER;
                    end else begin
                        o_cmd.wr_new   = 1'b1;
                        o_cmd.addr_inc = 1'b1;
                        n_state        = S_SH_RD;
                    end
                end else begin
                    o_cmd.addr_inc = 1'b1;
                    n_state        = S_RD;
                end
            end
            S_SH_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_SH_EV;
            end
            S_SH_EV: begin
                o_cmd.wr_held = 1'b1;
                if (i_stat.at_end) begin
                    o_cmd.bump_used = 1'b1;
                    n_state         = S_AFTER;
                end else begin
                    o_cmd.addr_inc = 1'b1;
                    n_state        = S_SH_RD;
                end
            end
            S_AFTER: begin
                if (!i_stat.is_last) begin
                    n_state = S_IDLE;
                end else if (i_stat.empty) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    o_cmd.addr_clr = 1'b1;
                    n_state        = S_E_RD;
                end
            end
            S_E_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_E_EV;
            end
            S_E_EV: begin
                o_cmd.eval_step = 1'b1;
                if (i_stat.last_entry) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    o_cmd.addr_inc = 1'b1;
                    n_state        = S_E_RD;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef ASSERT_OFF
    a_write_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.wr_new && o_cmd.wr_inc))
        else $error("new entry and count increment in the same cycle");
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_stat.out_free)
        else $error("result loaded over an untaken result");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == S_CHECK)
        else $error("transfer did not start a merge");
`endif

endmodule

### src/fns_dp.sv
// Datapath of the five-number summary block: sorted table memory, counters,
// rank capture, mean divider and the result register. Depends on fns_pkg.
module fns_dp import fns_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_stat                    o_stat,
    input  logic signed [DATA_W-1:0] i_sample,
    input  logic                     i_last,
    input  logic                     i_stall,
    output logic                     o_valid,
    output logic signed [DATA_W-1:0] o_minimum,
    output logic signed [DATA_W-1:0] o_first_quartile,
    output logic signed [DATA_W-1:0] o_median,
    output logic signed [DATA_W-1:0] o_third_quartile,
    output logic signed [DATA_W-1:0] o_maximum,
    output logic signed [DATA_W-1:0] o_average,
    output logic        [CNT_W-1:0]  o_sample_count,
    output logic        [1:0]        o_status
);

    logic signed [DATA_W-1:0] r_val_mem [MAX_DISTINCT];
    logic        [CNT_W-1:0]  r_cnt_mem [MAX_DISTINCT];

    logic signed [DATA_W-1:0] r_v, r_rd_val, r_held_val;
    logic        [CNT_W-1:0]  r_rd_cnt, r_held_cnt;
    logic                     r_last;
    logic        [USED_W-1:0] r_addr, r_used;
    logic        [CNT_W-1:0]  r_total;
    logic signed [SUM_W-1:0]  r_sum;
    logic        [1:0]        r_ovf;
    logic        [RANK_W-1:0] r_reached;
    logic signed [DATA_W-1:0] r_min, r_max;
    logic signed [DATA_W-1:0] r_cap [6];
    logic        [5:0]        r_found;
    logic        [SUM_W-1:0]  r_quo;
    logic        [CNT_W-1:0]  r_rem;
    logic        [DCNT_W-1:0] r_div_cnt;
    logic                     r_div_neg;
    logic                     r_out_valid;

    logic [ADDR_W-1:0] addr_idx;
    logic [RANK_W-1:0] reached_nx;
    logic [RANK_W-1:0] tgt [6];
    logic [RANK_W-1:0] half, quart, three_q;
    logic [RANK_W+1:0] triple;
    logic [CNT_W:0]    rem_sh;
    logic              rem_ge;
    logic signed [DATA_W-1:0] q1, md, q3, avg;

    assign addr_idx = r_addr[ADDR_W-1:0];

    assign o_stat.at_end     = (r_addr == r_used);
    assign o_stat.eq         = (r_rd_val == r_v);
    assign o_stat.gt         = (r_rd_val > r_v);
    assign o_stat.dist_full  = (r_used == USED_W'(MAX_DISTINCT));
    assign o_stat.samp_full  = (r_total == CNT_W'(MAX_SAMPLES));
    assign o_stat.last_entry = ((r_addr + USED_W'(1)) == r_used);
    assign o_stat.is_last    = r_last;
    assign o_stat.empty      = (r_used == '0);
    assign o_stat.div_last   = (r_div_cnt == DCNT_W'(SUM_W - 1));
    assign o_stat.out_free   = !r_out_valid || !i_stall;

    // Rank targets: a pair (lo, hi) per statistic; equal ranks give the value itself.
    always_comb begin
        half    = RANK_W'(r_total >> 1);
        quart   = RANK_W'(r_total >> 2);
        triple  = (RANK_W+2)'(r_total) + (RANK_W+2)'({r_total, 1'b0});
        three_q = RANK_W'(triple >> 2);
        tgt[0]  = (r_total[1:0] == 2'b00) ? quart : quart + RANK_W'(1);
        tgt[1]  = quart + RANK_W'(1);
        tgt[2]  = r_total[0] ? half + RANK_W'(1) : half;
        tgt[3]  = half + RANK_W'(1);
        tgt[4]  = (r_total[1:0] == 2'b00) ? three_q : three_q + RANK_W'(1);
        tgt[5]  = three_q + RANK_W'(1);
    end

    assign reached_nx = r_reached + RANK_W'(r_rd_cnt);

    function automatic logic signed [DATA_W-1:0] floor_avg(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic signed [DATA_W:0] s;
        s = (DATA_W+1)'(a) + (DATA_W+1)'(b);
        return s[DATA_W:1];
    endfunction

    assign q1  = floor_avg(r_cap[0], r_cap[1]);
    assign md  = floor_avg(r_cap[2], r_cap[3]);
    assign q3  = floor_avg(r_cap[4], r_cap[5]);
    assign avg = r_div_neg ? -r_quo[DATA_W-1:0] : r_quo[DATA_W-1:0];

    assign rem_sh = {r_rem, r_quo[SUM_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, r_total});

    // Table memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_val <= r_val_mem[addr_idx];
            r_rd_cnt <= r_cnt_mem[addr_idx];
        end
        if (i_cmd.wr_new) begin
            r_val_mem[addr_idx] <= r_v;
            r_cnt_mem[addr_idx] <= CNT_W'(1);
        end else if (i_cmd.wr_inc) begin
            r_cnt_mem[addr_idx] <= r_rd_cnt + CNT_W'(1);
        end else if (i_cmd.wr_held) begin
            r_val_mem[addr_idx] <= r_held_val;
            r_cnt_mem[addr_idx] <= r_held_cnt;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_v    <= i_sample;
            r_last <= i_last;
        end
        if (i_cmd.wr_new || i_cmd.wr_held) begin
            r_held_val <= r_rd_val;
            r_held_cnt <= r_rd_cnt;
        end
        if (i_cmd.addr_clr) begin
            r_reached <= '0;
            r_found   <= '0;
        end else if (i_cmd.eval_step) begin
            r_reached <= reached_nx;
            if (r_addr == '0) begin
                r_min <= r_rd_val;
            end
            if (o_stat.last_entry) begin
                r_max <= r_rd_val;
            end
            for (int i = 0; i < 6; i++) begin
                if (!r_found[i] && reached_nx >= tgt[i]) begin
                    r_cap[i]   <= r_rd_val;
                    r_found[i] <= 1'b1;
                end
            end
        end
        if (i_cmd.div_start) begin
            r_div_neg <= r_sum[SUM_W-1];
            r_quo     <= r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
            r_rem     <= '0;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_quo     <= {r_quo[SUM_W-2:0], rem_ge};
            r_rem     <= rem_ge ? CNT_W'(rem_sh - {1'b0, r_total}) : rem_sh[CNT_W-1:0];
            r_div_cnt <= r_div_cnt + DCNT_W'(1);
        end
        if (i_cmd.out_load) begin
            o_minimum        <= (r_total == '0) ? '0 : r_min;
            o_first_quartile <= (r_total == '0) ? '0 : q1;
            o_median         <= (r_total == '0) ? '0 : md;
            o_third_quartile <= (r_total == '0) ? '0 : q3;
            o_maximum        <= (r_total == '0) ? '0 : r_max;
            o_average        <= (r_total == '0) ? '0 : avg;
            o_sample_count   <= r_total;
            o_status         <= r_ovf;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr      <= '0;
            r_used      <= '0;
            r_total     <= '0;
            r_sum       <= '0;
            r_ovf       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.addr_clr) begin
                r_addr <= '0;
            end else if (i_cmd.addr_inc) begin
                r_addr <= r_addr + USED_W'(1);
            end
            if (i_cmd.drop_samples && r_ovf == ST_OK) begin
                r_ovf <= ST_SAMPLES;
            end
            if (i_cmd.drop_distinct && r_ovf == ST_OK) begin
                r_ovf <= ST_DISTINCT;
            end
            if (i_cmd.wr_new || i_cmd.wr_inc) begin
                r_total <= r_total + CNT_W'(1);
                r_sum   <= r_sum + SUM_W'(r_v);
            end
            if (i_cmd.bump_used) begin
                r_used <= r_used + USED_W'(1);
            end
            if (i_cmd.out_load) begin
                r_used      <= '0;
                r_total     <= '0;
                r_sum       <= '0;
                r_ovf       <= ST_OK;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;

`ifndef ASSERT_OFF
    a_used_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= USED_W'(MAX_DISTINCT))
        else $error("distinct table fill beyond its depth");
    a_total_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CNT_W'(MAX_SAMPLES))
        else $error("sample count beyond its limit");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> (r_used == '0 && r_total == '0 && o_valid))
        else $error("store not cleared after a result");
    a_used_le_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        USED_W'(r_used) <= USED_W'(MAX_DISTINCT) && (r_used == '0 || r_total != '0))
        else $error("table entries without samples");
`endif

endmodule

### src/five_number_summary.sv
// Top level of the five-number summary block.
// Depends on fns_pkg, fns_ctrl and fns_dp.

// Each transfer on the input carries one signed Q16.16 sample, which is merged
// into a sorted table of up to MAX_DISTINCT distinct values with a count for
// each. The merge walks the table from the smallest value with one registered
// memory read per entry, and a new value ripples the larger entries up one
// place. A sample keeps the input stalled until its merge is done, and the
// next transfer is taken once the stall drops. A sample marked last is
// merged like any other and then starts the summary: a second walk over the
// table picks minimum, quartiles, median and maximum by rank, and a
// bit-serial divider forms the truncated mean. One result transfer follows,
// carrying the count of accepted samples and a status (0 ok, 1 distinct
// table full, 2 sample count full; the first one seen wins), and the store
// is cleared for the next set. Samples that do not fit are dropped. The
// result waits in an output register, so the next set can start loading
// while it is still untaken. The input is stalled while a sample or summary
// is in work. The table needs no clearing after reset.
module five_number_summary import fns_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic signed [DATA_W-1:0] i_sample,
    input  logic                     i_last,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [DATA_W-1:0] o_minimum,
    output logic signed [DATA_W-1:0] o_first_quartile,
    output logic signed [DATA_W-1:0] o_median,
    output logic signed [DATA_W-1:0] o_third_quartile,
    output logic signed [DATA_W-1:0] o_maximum,
    output logic signed [DATA_W-1:0] o_average,
    output logic        [CNT_W-1:0]  o_sample_count,
    output logic        [1:0]        o_status
);

    t_cmd  cmd;
    t_stat stat;

    fns_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    fns_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_sample         (i_sample),
        .i_last           (i_last),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_minimum        (o_minimum),
        .o_first_quartile (o_first_quartile),
        .o_median         (o_median),
        .o_third_quartile (o_third_quartile),
        .o_maximum        (o_maximum),
        .o_average        (o_average),
        .o_sample_count   (o_sample_count),
        .o_status         (o_status)
    );

endmodule
